FILE: rtl/fdtb_pkg.sv
// Shared codes and constants for the frame delay timer bank.
package fdtb_pkg;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_START   = 2'd1,
		ACT_RESTART = 2'd2,
		ACT_STOP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		EV_ACK     = 2'd0,
		EV_STARTED = 2'd1,
		EV_FIRED   = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NO_SLOT = 2'd2
	} status_t;

	localparam logic [9:0]  FPS_RESET   = 10'd60;
	localparam logic [15:0] LIMIT_MAX   = 16'hFFFF;
	localparam int          MAX_REPORTS = 16;
	localparam int          REPORT_W    = 5;
	localparam int          PROD_W      = 26;
	// floor(p / 1000) == (p * RECIP_MULT) >> RECIP_SHIFT for every p below 2**26
	localparam int          RECIP_W     = 27;
	localparam logic [RECIP_W-1:0] RECIP_MULT = 27'd68719477;
	localparam int          RECIP_SHIFT = 36;
	localparam int          QUO_W       = 17;

endpackage

FILE: rtl/fdtb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module fdtb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/frame_delay_timer_bank_core.sv
// Frame delay timer bank: one-shot frame timers kept in two synchronous RAMs.
//
// Input channel (in_valid/in_stall) carries one command word: tick, start,
// restart or stop. Output channel (out_valid/out_stall) returns result words
// with slot, event_res, status and last. One command is worked at a time;
// in_stall is high from acceptance until its last result is in the output
// register.
// Start: the ms-to-frames multiply (product, then reciprocal product) is
// registered, then a scan of one slot per cycle finds the lowest free slot.
// Restart/stop: done once the output register is free. Tick: walks the count
// and limit RAMs one slot per cycle with a read-ahead of one, unless held up;
// fired reports leave in ascending slot order, the final one marked last.
// The output register takes a new word while the old one is being taken;
// while out_stall holds a word, the walk pauses on the next report.
// Reset clears all timers (active flags only) and sets frames_per_second
// to 60. The frame rate is written through cfg_write_en/cfg_write_data.
module frame_delay_timer_bank_core #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [9:0]  cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic        paused,
	input  logic [15:0] duration_ms,
	input  logic        pause_sensitive,
	input  logic [3:0]  target_slot,
	input  logic        fire_on_stop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  slot,
	output logic [1:0]  event_res,
	output logic [1:0]  status,
	output logic        last
);

	import fdtb_pkg::*;

	localparam int SW = TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [SW-1:0] LAST_IDX = SW'(TIMER_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_MULT,
		S_SCAN,
		S_TARGET
	} state_t;

	state_t state_q;

	logic [9:0]             fps_q;
	logic [TIMER_SLOTS-1:0] active_q;

	logic [1:0]  action_q;
	logic        paused_q;
	logic [15:0] ms_q;
	logic        psens_q;
	logic [3:0]  target_q;
	logic        fire_q;

	logic [PROD_W-1:0]         prod_q;
	logic [PROD_W+RECIP_W-1:0] recip_q;

	logic [SW-1:0]       rd_idx_q;
	logic                rd_done_q;
	logic                tick_vld_s1;
	logic [SW-1:0]       tick_idx_s1;
	logic [REPORT_W-1:0] n_q;
	logic                pend_vld_q;
	logic [SW-1:0]       pend_slot_q;
	logic [SW-1:0]       scan_idx_q;

	logic       out_vld_q;
	logic [3:0] out_slot_q;
	logic [1:0] out_event_q;
	logic [1:0] out_status_q;
	logic       out_last_q;

	logic          cnt_we;
	logic [SW-1:0] cnt_waddr;
	logic [15:0]   cnt_wdata;
	logic [15:0]   cnt_rdata;
	logic          lim_we;
	logic [16:0]   lim_wdata;
	logic [16:0]   lim_rdata;
	logic          rd_en;

	logic             out_free;
	logic             tick_act;
	logic [15:0]      cnt_nx;
	logic             tick_fire;
	logic             blocked;
	logic             tick_adv;
	logic             flush;
	logic             claim;
	logic             full;
	logic [SW-1:0]    tgt_idx;
	logic             tgt_ok;
	logic [QUO_W-1:0] quo;
	logic [15:0]      limit_calc;

	logic       out_load;
	logic [3:0] out_slot_d;
	logic [1:0] out_event_d;
	logic [1:0] out_status_d;
	logic       out_last_d;

	fdtb_ram #(.WIDTH(16), .DEPTH(TIMER_SLOTS)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (cnt_rdata)
	);

	// word: {holds_on_pause, frame_limit}
	fdtb_ram #(.WIDTH(17), .DEPTH(TIMER_SLOTS)) u_limit_ram (
		.clk   (clk),
		.we    (lim_we),
		.waddr (scan_idx_q),
		.wdata (lim_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (lim_rdata)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_vld_q;
	assign slot      = out_slot_q;
	assign event_res = out_event_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

	assign out_free = !out_vld_q || !out_stall;

	assign quo        = recip_q[RECIP_SHIFT +: QUO_W];
	assign limit_calc = (ms_q == 16'd0) ? 16'd1 :
	                    (quo[QUO_W-1] ? LIMIT_MAX : quo[15:0]);

	assign tgt_idx = SW'(target_q);
	assign tgt_ok  = (9'(target_q) < 9'(TIMER_SLOTS)) && active_q[tgt_idx];

	assign tick_act  = active_q[tick_idx_s1] && !(lim_rdata[16] && paused_q);
	assign cnt_nx    = (cnt_rdata == LIMIT_MAX) ? cnt_rdata : cnt_rdata + 16'd1;
	assign tick_fire = tick_act && (cnt_nx >= lim_rdata[15:0])
	                   && (n_q < REPORT_W'(MAX_REPORTS));
	assign blocked   = tick_vld_s1 && tick_fire && pend_vld_q && !out_free;
	assign tick_adv  = (state_q == S_TICK) && !blocked;
	assign rd_en     = tick_adv && !rd_done_q;
	assign flush     = (state_q == S_TICK) && rd_done_q && !tick_vld_s1;

	assign claim = (state_q == S_SCAN) && out_free && !active_q[scan_idx_q];
	assign full  = (state_q == S_SCAN) && out_free && active_q[scan_idx_q]
	               && (scan_idx_q == LAST_IDX);

	assign lim_we    = claim;
	assign lim_wdata = {psens_q, limit_calc};

	always_comb begin
		cnt_we       = 1'b0;
		cnt_waddr    = tick_idx_s1;
		cnt_wdata    = cnt_nx;
		out_load     = 1'b0;
		out_slot_d   = 4'(pend_slot_q);
		out_event_d  = EV_FIRED;
		out_status_d = ST_OK;
		out_last_d   = 1'b0;
		case (state_q)
			S_TICK: begin
				if (tick_adv && tick_vld_s1 && tick_act) begin
					cnt_we = 1'b1;
				end
				if (tick_adv && tick_vld_s1 && tick_fire && pend_vld_q) begin
					out_load = 1'b1;
				end
				if (flush && pend_vld_q && out_free) begin
					out_load   = 1'b1;
					out_last_d = 1'b1;
				end
			end
			S_SCAN: begin
				if (claim) begin
					cnt_we       = 1'b1;
					cnt_waddr    = scan_idx_q;
					cnt_wdata    = 16'd0;
					out_load     = 1'b1;
					out_slot_d   = 4'(scan_idx_q);
					out_event_d  = EV_STARTED;
					out_last_d   = 1'b1;
				end else if (full) begin
					out_load     = 1'b1;
					out_slot_d   = 4'd0;
					out_event_d  = EV_ACK;
					out_status_d = ST_FULL;
					out_last_d   = 1'b1;
				end
			end
			S_TARGET: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_slot_d = target_q;
					out_last_d = 1'b1;
					if (!tgt_ok) begin
						out_event_d  = EV_ACK;
						out_status_d = ST_NO_SLOT;
					end else if (action_q == ACT_RESTART) begin
						out_event_d = EV_ACK;
						cnt_we      = 1'b1;
						cnt_waddr   = tgt_idx;
						cnt_wdata   = 16'd0;
					end else begin
						out_event_d = fire_q ? EV_FIRED : EV_ACK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// frame-limit arithmetic: fps * ms, then divide by 1000 via reciprocal
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			prod_q <= PROD_W'(fps_q) * PROD_W'(duration_ms);
		end
		recip_q <= (PROD_W+RECIP_W)'(prod_q) * (PROD_W+RECIP_W)'(RECIP_MULT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fps_q        <= FPS_RESET;
			active_q     <= '0;
			action_q     <= ACT_TICK;
			paused_q     <= 1'b0;
			ms_q         <= '0;
			psens_q      <= 1'b0;
			target_q     <= '0;
			fire_q       <= 1'b0;
			rd_idx_q     <= '0;
			rd_done_q    <= 1'b0;
			tick_vld_s1  <= 1'b0;
			tick_idx_s1  <= '0;
			n_q          <= '0;
			pend_vld_q   <= 1'b0;
			pend_slot_q  <= '0;
			scan_idx_q   <= '0;
			out_vld_q    <= 1'b0;
			out_slot_q   <= '0;
			out_event_q  <= EV_ACK;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				fps_q <= cfg_write_data;
			end
			if (out_load) begin
				out_vld_q    <= 1'b1;
				out_slot_q   <= out_slot_d;
				out_event_q  <= out_event_d;
				out_status_q <= out_status_d;
				out_last_q   <= out_last_d;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						action_q <= action;
						paused_q <= paused;
						ms_q     <= duration_ms;
						psens_q  <= pause_sensitive;
						target_q <= target_slot;
						fire_q   <= fire_on_stop;
						case (action)
							ACT_TICK: begin
								state_q     <= S_TICK;
								rd_idx_q    <= '0;
								rd_done_q   <= 1'b0;
								tick_vld_s1 <= 1'b0;
								n_q         <= '0;
								pend_vld_q  <= 1'b0;
							end
							ACT_START: begin
								state_q <= S_MULT;
							end
							default: begin
								state_q <= S_TARGET;
							end
						endcase
					end
				end
				S_TICK: begin
					if (tick_adv) begin
						if (tick_vld_s1 && tick_fire) begin
							active_q[tick_idx_s1] <= 1'b0;
							n_q                   <= n_q + REPORT_W'(1);
							pend_vld_q            <= 1'b1;
							pend_slot_q           <= tick_idx_s1;
						end
						tick_vld_s1 <= !rd_done_q;
						tick_idx_s1 <= rd_idx_q;
						if (!rd_done_q) begin
							if (rd_idx_q == LAST_IDX) begin
								rd_done_q <= 1'b1;
							end else begin
								rd_idx_q <= rd_idx_q + SW'(1);
							end
						end
					end
					if (flush && (!pend_vld_q || out_free)) begin
						state_q <= S_IDLE;
					end
				end
				S_MULT: begin
					state_q    <= S_SCAN;
					scan_idx_q <= '0;
				end
				S_SCAN: begin
					if (claim) begin
						active_q[scan_idx_q] <= 1'b1;
						state_q              <= S_IDLE;
					end else if (full) begin
						state_q <= S_IDLE;
					end else if (active_q[scan_idx_q] && (scan_idx_q != LAST_IDX)) begin
						scan_idx_q <= scan_idx_q + SW'(1);
					end
				end
				S_TARGET: begin
					if (out_free) begin
						if (tgt_ok && (action_q == ACT_STOP)) begin
							active_q[tgt_idx] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/sv/frame_delay_timer_bank_checker.sv
// Scoreboard for the frame delay timer bank: tracks timer state, predicts and checks result words.
module frame_delay_timer_bank_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [9:0]  cfg_write_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic        paused,
	input  logic [15:0] duration_ms,
	input  logic        pause_sensitive,
	input  logic [3:0]  target_slot,
	input  logic        fire_on_stop,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  slot,
	input  logic [1:0]  event_res,
	input  logic [1:0]  status,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          checked_count,
	output int          fired_count,
	output int          full_count,
	output logic [15:0] live_slots
);
	timeunit 1ns;
	timeprecision 1ps;
	import fdtb_pkg::*;

	localparam int SLOTS = 16;

	typedef struct packed {
		logic [3:0] slot;
		event_t     ev;
		status_t    st;
		logic       last;
	} timer_report_t;

	timer_report_t report_q[$];
	logic [9:0]    fps;
	logic          run_on[SLOTS];
	logic [15:0]   frames_seen[SLOTS];
	logic [15:0]   frames_due[SLOTS];
	logic          hold_on_pause[SLOTS];

	function automatic logic [15:0] frames_for_ms(input logic [9:0] rate, input logic [15:0] ms);
		logic [31:0] quo;
		if (ms == 16'd0)
			return 16'd1;
		quo = (32'(rate) * 32'(ms)) / 32'd1000;
		return (quo > 32'(LIMIT_MAX)) ? LIMIT_MAX : quo[15:0];
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic push_report(input logic [3:0] s, input event_t e, input status_t t,
			input logic l);
		report_q.push_back(timer_report_t'{s, e, t, l});
	endtask

	task automatic apply_command;
		int last_idx;
		int free_idx;
		int fired;
		last_idx = -1;
		free_idx = -1;
		fired = 0;
		case (action_t'(action))
			ACT_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (run_on[i] && !(hold_on_pause[i] && paused)) begin
						if (frames_seen[i] != LIMIT_MAX)
							frames_seen[i]++;
						if (frames_seen[i] >= frames_due[i] && fired < MAX_REPORTS) begin
							push_report(4'(i), EV_FIRED, ST_OK, 1'b0);
							last_idx = report_q.size() - 1;
							run_on[i] = 1'b0;
							fired++;
						end
					end
				end
				if (last_idx >= 0)
					report_q[last_idx].last = 1'b1;
			end
			ACT_START: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!run_on[i])
						free_idx = i;
				if (free_idx < 0) begin
					push_report(4'd0, EV_ACK, ST_FULL, 1'b1);
				end else begin
					run_on[free_idx] = 1'b1;
					frames_seen[free_idx] = 16'd0;
					frames_due[free_idx] = frames_for_ms(fps, duration_ms);
					hold_on_pause[free_idx] = pause_sensitive;
					push_report(4'(free_idx), EV_STARTED, ST_OK, 1'b1);
				end
			end
			default: begin
				if (!run_on[target_slot]) begin
					push_report(target_slot, EV_ACK, ST_NO_SLOT, 1'b1);
				end else if (action_t'(action) == ACT_RESTART) begin
					frames_seen[target_slot] = 16'd0;
					push_report(target_slot, EV_ACK, ST_OK, 1'b1);
				end else begin
					run_on[target_slot] = 1'b0;
					push_report(target_slot, fire_on_stop ? EV_FIRED : EV_ACK, ST_OK, 1'b1);
				end
			end
		endcase
	endtask

	task automatic check_word;
		timer_report_t want;
		checked_count++;
		if (event_res == EV_FIRED)
			fired_count++;
		if (status == ST_FULL)
			full_count++;
		if (report_q.size() == 0) begin
			report_mismatch($sformatf("unexpected word slot %0d event %0d status %0d last %0d",
				slot, event_res, status, last));
		end else begin
			want = report_q.pop_front();
			if (slot !== want.slot)
				report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
			if (event_res !== want.ev)
				report_mismatch($sformatf("event %0d, want %0d (slot %0d)",
					event_res, want.ev, want.slot));
			if (status !== want.st)
				report_mismatch($sformatf("status %0d, want %0d (slot %0d)",
					status, want.st, want.slot));
			if (last !== want.last)
				report_mismatch($sformatf("last %0d, want %0d (slot %0d)",
					last, want.last, want.slot));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps = FPS_RESET;
			report_q.delete();
			for (int i = 0; i < SLOTS; i++) begin
				run_on[i] = 1'b0;
				frames_seen[i] = 16'd0;
				frames_due[i] = 16'd0;
				hold_on_pause[i] = 1'b0;
			end
			fail_count = 0;
			checked_count = 0;
			fired_count = 0;
			full_count = 0;
		end else begin
			if (cfg_write_en)
				fps = cfg_write_data;
			// words leaving now belong to earlier commands
			if (out_valid && !out_stall)
				check_word();
			if (in_valid && !in_stall)
				apply_command();
		end
		pending = report_q.size();
		for (int i = 0; i < SLOTS; i++)
			live_slots[i] = run_on[i];
	end

endmodule

FILE: tb/sv/frame_delay_timer_bank_core_test.sv
// Top-level testbench for frame_delay_timer_bank_core: clock, reset, stimulus and verdict.
module frame_delay_timer_bank_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fdtb_pkg::*;

	localparam int RANDOM_PER_PHASE = 75;
	localparam int SETTLE_CYCLES    = 40;
	localparam int LONG_HOLD        = 300;
	localparam int RATE_PHASES      = 6;

	logic        clk;
	logic        arst_n;
	logic        cfg_write_en;
	logic [9:0]  cfg_write_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic        paused;
	logic [15:0] duration_ms;
	logic        pause_sensitive;
	logic [3:0]  target_slot;
	logic        fire_on_stop;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  slot;
	logic [1:0]  event_res;
	logic [1:0]  status;
	logic        last;

	int          fail_count;
	int          pending;
	int          checked_count;
	int          fired_count;
	int          full_count;
	logic [15:0] live_slots;

	int          sent_count;
	int          cur_fps;
	bit          hold_req;
	bit          hold_done;
	logic [9:0]  phase_fps[RATE_PHASES];

	frame_delay_timer_bank_core dut (.*);

	frame_delay_timer_bank_checker u_check (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

	task automatic send_word(input action_t act, input logic p, input logic [15:0] ms,
			input logic ps, input logic [3:0] tgt, input logic fire);
		@(negedge clk);
		action = act;
		paused = p;
		duration_ms = ms;
		pause_sensitive = ps;
		target_slot = tgt;
		fire_on_stop = fire;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (cycles - 1)
				@(negedge clk);
		end
	endtask

	task automatic wait_quiet;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_rate(input logic [9:0] rate);
		@(negedge clk);
		cfg_write_en = 1'b1;
		cfg_write_data = rate;
		@(negedge clk);
		cfg_write_en = 1'b0;
		cur_fps = rate;
	endtask

	// mostly aim restart/stop at a running timer
	function automatic logic [3:0] pick_target();
		int base;
		base = $urandom_range(0, 15);
		if (live_slots != 16'd0 && $urandom_range(0, 3) != 0)
			for (int k = 0; k < 16; k++)
				if (live_slots[(base + k) % 16])
					return 4'((base + k) % 16);
		return 4'(base);
	endfunction

	task automatic send_random;
		action_t     act;
		logic [15:0] ms;
		int          roll;
		int          short_max;
		roll = $urandom_range(0, 99);
		act = (roll < 40) ? ACT_TICK : (roll < 70) ? ACT_START :
			(roll < 85) ? ACT_RESTART : ACT_STOP;
		// short delays keep limits to a handful of frames at any rate
		short_max = 10000 / (cur_fps + 1) + 2;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			ms = 16'($urandom_range(0, short_max));
		else if (roll < 8)
			ms = 16'($urandom_range(0, 20));
		else
			ms = 16'($urandom);
		send_word(act, 1'($urandom), ms, 1'($urandom), pick_target(), 1'($urandom));
	endtask

	initial begin
		int span;
		int mode;
		int hold_left;
		span = 0;
		mode = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(16, 96);
				end
				span--;
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 7) != 0);
					default: out_stall = !out_stall;
				endcase
			end
		end
	end

	initial begin
		int burst_left;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = 10'd0;
		in_valid = 1'b0;
		action = ACT_TICK;
		paused = 1'b0;
		duration_ms = 16'd0;
		pause_sensitive = 1'b0;
		target_slot = 4'd0;
		fire_on_stop = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		sent_count = 0;
		cur_fps = FPS_RESET;
		phase_fps = '{10'd1, 10'd1000, 10'd1023, 10'd0, 10'd0, 10'd60};
		phase_fps[4] = 10'($urandom_range(2, 998));
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, missing slots, zero and tiny delays, pause hold,
		// full table, stop with and without fire, one tick firing many timers
		send_word(ACT_TICK, 1'b0, 16'd0, 1'b0, 4'd0, 1'b0);
		send_word(ACT_RESTART, 1'b0, 16'd0, 1'b0, 4'd5, 1'b0);
		send_word(ACT_STOP, 1'b0, 16'd0, 1'b0, 4'd15, 1'b1);
		send_word(ACT_START, 1'b0, 16'd0, 1'b1, 4'd0, 1'b0);
		send_word(ACT_START, 1'b0, 16'hFFFF, 1'b0, 4'd0, 1'b0);
		send_word(ACT_START, 1'b0, 16'd16, 1'b0, 4'd0, 1'b0);
		send_word(ACT_TICK, 1'b1, 16'd0, 1'b0, 4'd0, 1'b0);
		send_word(ACT_TICK, 1'b0, 16'd0, 1'b0, 4'd0, 1'b0);
		send_word(ACT_RESTART, 1'b0, 16'd0, 1'b0, 4'd1, 1'b0);
		for (int k = 0; k < 15; k++)
			send_word(ACT_START, 1'b0, (k % 2) ? 16'd0 : 16'd16, 1'(k % 2), 4'd0, 1'b0);
		send_word(ACT_START, 1'b0, 16'd100, 1'b0, 4'd0, 1'b0);
		send_word(ACT_STOP, 1'b0, 16'd0, 1'b0, 4'd1, 1'b1);
		send_word(ACT_STOP, 1'b0, 16'd0, 1'b0, 4'd3, 1'b0);
		send_word(ACT_TICK, 1'b0, 16'd0, 1'b0, 4'd0, 1'b0);
		wait_quiet();

		for (int p = 0; p < RATE_PHASES; p++) begin
			write_rate(phase_fps[p]);
			if (p == 1)
				hold_req = 1'b1;
			burst_left = $urandom_range(1, 8);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_random();
				burst_left--;
				if (burst_left == 0) begin
					idle_sender($urandom_range(0, 8));
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
						$urandom_range(1, 8);
				end
			end
			wait_quiet();
		end

		$display("ran %0d commands across %0d frame-rate settings, with a %0d-cycle output hold-off",
			sent_count, RATE_PHASES + 1, LONG_HOLD);
		$display("checked %0d result words: %0d fired reports, %0d table-full replies",
			checked_count, fired_count, full_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
